### rtl/size_class_free_list_allocator_assert.svh
// Assertion macros for the size-class free-list allocator.
// Included inside module bodies; needs clock and reset names as arguments.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SCFL_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");
// next-cycle implication
`define SCFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");
`else
`define SCFL_ASSERT(label, clk, rst, ante, cons)
`define SCFL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/scfl_pkg.sv
// Shared types and constants for the size-class free-list allocator.
// No dependencies.
`default_nettype none

package scfl_pkg;

  localparam int POOL_GRANULES = 4096;
  localparam int ADDR_W        = 12;              // granule index
  localparam int LINK_W        = ADDR_W + 1;      // index plus empty mark
  localparam int GRANULE_SHIFT = 3;               // 8-byte granules
  localparam int CLASS_W       = 4;
  localparam int CLASS_COUNT   = 16;
  localparam int BLK_W         = CLASS_W + 1;     // block size in granules, 1..16
  localparam int CNT_W         = 6;
  localparam int BYTES_W       = 16;
  localparam int USAGE_W       = 16;
  localparam int STATUS_W      = 2;
  localparam int DATA_W        = 32;

  localparam logic [LINK_W-1:0]  LIST_EMPTY      = 13'd4096;
  localparam logic [BYTES_W-1:0] MAX_SMALL_BYTES = 16'd128;
  localparam logic [CNT_W-1:0]   MAX_REFILL      = 6'd32;
  localparam logic [CNT_W-1:0]   REFILL_RESET    = 6'd20;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO      = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic REG_BLOCKS_PER_REFILL = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_CARVE
  } fsm_t;

endpackage

`default_nettype wire

### rtl/size_class_free_list_allocator.sv
// Size-class free-list allocator: top level with link memory and sequencer.
// Depends on scfl_pkg and size_class_free_list_allocator_assert.svh.
`default_nettype none

// Allocates and frees granule blocks of a 4096-granule pool, 8 bytes per
// granule, on 16 size classes (1..16 granules).
// Input stream: s_tuser = command (0 alloc, 1 free), s_tdata holds the size
// in bytes and the address being freed. One result transaction per input on
// the m_ side: status in m_tuser, granted address and bytes in use in m_tdata.
// APB register 0 (blocks_per_refill) sets how many blocks an empty class
// takes from the pool cursor; write it only while the block is idle.
// One transaction is worked on at a time. Steps from accept to result valid:
//   zero size, too large, free, pool exhausted : execute step only
//   allocate from a non-empty list              : execute, then link memory read
//   allocate with refill of n blocks            : execute, then one link write each
// With a ready receiver the next input is taken once the sequencer is idle again.
// The link memory has a single write port, so a refill writes one link a cycle;
// only its last write waits until the output register frees up.
// A new input is taken once the result of the previous one sits in the
// output register; a stalled receiver holds the result and the sequencer
// waits at its final step until the output register frees up.
// Reset: all class lists empty, pool cursor 0, usage 0, refill count 20.
// The link memory is not cleared; it is only read at addresses on a list.
module size_class_free_list_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [scfl_pkg::DATA_W-1:0]   s_tdata,   // [15:0] request_bytes, [27:16] block_address
  input  wire logic                          s_tuser,   // [0] command
  // result stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [scfl_pkg::DATA_W-1:0]        m_tdata,   // [11:0] granted_address, [27:12] bytes_used
  output logic [scfl_pkg::STATUS_W-1:0]      m_tuser,   // [1:0] status
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import scfl_pkg::*;

  `include "size_class_free_list_allocator_assert.svh"

  // ---------------- state ----------------
  fsm_t state, state_next;

  logic [LINK_W-1:0]  heads [CLASS_COUNT];   // class list heads, LIST_EMPTY = empty
  logic [LINK_W-1:0]  cursor, cursor_next;   // next uncarved granule
  logic [USAGE_W-1:0] usage, usage_next;
  logic [CNT_W-1:0]   refill_cfg;

  // latched transaction
  logic               cmd;
  logic [BYTES_W-1:0] req_bytes;
  logic [ADDR_W-1:0]  blk_addr;

  // refill / pop working registers
  logic [CNT_W-1:0]   want, want_next;
  logic [CNT_W-1:0]   carve_idx, carve_idx_next;
  logic [ADDR_W-1:0]  base, base_next;
  logic [LINK_W-1:0]  first_link, first_link_next;
  logic [ADDR_W-1:0]  pop_addr, pop_addr_next;

  // output register
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_granted;
  logic [USAGE_W-1:0]  out_used;

  // link memory
  logic [LINK_W-1:0] links [POOL_GRANULES];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [LINK_W-1:0] mem_wdata, mem_rdata;

  // head update
  logic               heads_we;
  logic [CLASS_W-1:0] heads_idx;
  logic [LINK_W-1:0]  heads_wd;

  // result hand-off
  logic                emit;
  logic [STATUS_W-1:0] emit_status;
  logic [ADDR_W-1:0]   emit_granted;
  logic                out_free;

  // ---------------- derived values ----------------
  logic [BYTES_W-1:0] req_m1;
  logic [CLASS_W-1:0] cls;
  logic [BLK_W-1:0]   blk;
  logic [LINK_W-1:0]  cls_head;
  logic [LINK_W-1:0]  remaining;
  logic [LINK_W-1:0]  rem_m1;
  logic [CNT_W-1:0]   want_clamp;
  logic [LINK_W:0]    two_ahead;
  logic               link_more;
  logic [LINK_W-1:0]  carve_link;
  logic [USAGE_W:0]   usage_sum;
  logic [USAGE_W-1:0] usage_add, usage_sub;

  assign req_m1    = req_bytes - 16'd1;
  assign cls       = req_m1[GRANULE_SHIFT +: CLASS_W];
  assign blk       = {1'b0, cls} + 5'd1;
  assign cls_head  = heads[cls];
  assign remaining = LIST_EMPTY - cursor;
  assign rem_m1    = remaining - 13'd1;

  assign want_clamp = (refill_cfg == '0)        ? 6'd1 :
                      (refill_cfg > MAX_REFILL) ? MAX_REFILL : refill_cfg;

  // another block fits after this one, and the count allows it
  assign two_ahead  = {1'b0, cursor} + {8'd0, blk, 1'b0};
  assign link_more  = (({1'b0, carve_idx} + 7'd1) < {1'b0, want}) &&
                      (two_ahead <= {1'b0, LIST_EMPTY});
  assign carve_link = link_more ? (cursor + {8'd0, blk}) : LIST_EMPTY;

  assign usage_sum = {1'b0, usage} + {1'b0, req_bytes};
  assign usage_add = usage_sum[USAGE_W] ? {USAGE_W{1'b1}} : usage_sum[USAGE_W-1:0];
  assign usage_sub = (usage > req_bytes) ? (usage - req_bytes) : '0;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cursor_next     = cursor;
    usage_next      = usage;
    want_next       = want;
    carve_idx_next  = carve_idx;
    base_next       = base;
    first_link_next = first_link;
    pop_addr_next   = pop_addr;
    mem_we          = 1'b0;
    mem_waddr       = cursor[ADDR_W-1:0];
    mem_wdata       = LIST_EMPTY;
    mem_re          = 1'b0;
    mem_raddr       = cls_head[ADDR_W-1:0];
    heads_we        = 1'b0;
    heads_idx       = cls;
    heads_wd        = LIST_EMPTY;
    emit            = 1'b0;
    emit_status     = ST_OK;
    emit_granted    = '0;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          if (req_bytes == '0) begin
            emit        = 1'b1;
            emit_status = ST_ZERO;
            state_next  = S_IDLE;
          end else if (req_bytes > MAX_SMALL_BYTES) begin
            emit        = 1'b1;
            emit_status = ST_TOO_LARGE;
            state_next  = S_IDLE;
          end else if (cmd == CMD_FREE) begin
            // push onto the class list
            mem_we     = 1'b1;
            mem_waddr  = blk_addr;
            mem_wdata  = cls_head;
            heads_we   = 1'b1;
            heads_wd   = {1'b0, blk_addr};
            usage_next = usage_sub;
            emit       = 1'b1;
            state_next = S_IDLE;
          end else if (!cls_head[ADDR_W]) begin
            // pop: fetch the successor link
            mem_re        = 1'b1;
            pop_addr_next = cls_head[ADDR_W-1:0];
            state_next    = S_POP;
          end else if (remaining < {8'd0, blk}) begin
            // pool exhausted: leftover granules go to their own class
            if (cursor != LIST_EMPTY) begin
              mem_we    = 1'b1;
              mem_wdata = heads[rem_m1[CLASS_W-1:0]];
              heads_we  = 1'b1;
              heads_idx = rem_m1[CLASS_W-1:0];
              heads_wd  = cursor;
            end
            cursor_next = LIST_EMPTY;
            emit        = 1'b1;
            emit_status = ST_OOM;
            state_next  = S_IDLE;
          end else begin
            want_next      = want_clamp;
            carve_idx_next = '0;
            base_next      = cursor[ADDR_W-1:0];
            state_next     = S_CARVE;
          end
        end
      end

      S_CARVE: begin
        // last block also hands out the first one, so wait for the output
        if (link_more || out_free) begin
          mem_we         = 1'b1;
          mem_wdata      = carve_link;
          cursor_next    = cursor + {8'd0, blk};
          carve_idx_next = carve_idx + 6'd1;
          if (carve_idx == '0) begin
            first_link_next = carve_link;
          end
          if (!link_more) begin
            heads_we     = 1'b1;
            heads_wd     = (carve_idx == '0) ? carve_link : first_link;
            usage_next   = usage_add;
            emit         = 1'b1;
            emit_granted = base;
            state_next   = S_IDLE;
          end
        end
      end

      S_POP: begin
        if (out_free) begin
          heads_we     = 1'b1;
          heads_wd     = mem_rdata;
          usage_next   = usage_add;
          emit         = 1'b1;
          emit_granted = pop_addr;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor   <= '0;
      usage    <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < CLASS_COUNT; i++) begin
        heads[i] <= LIST_EMPTY;
      end
    end else begin
      cursor <= cursor_next;
      usage  <= usage_next;
      if (heads_we) begin
        heads[heads_idx] <= heads_wd;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd       <= s_tuser;
      req_bytes <= s_tdata[15:0];
      blk_addr  <= s_tdata[27:16];
    end
    want       <= want_next;
    carve_idx  <= carve_idx_next;
    base       <= base_next;
    first_link <= first_link_next;
    pop_addr   <= pop_addr_next;
    if (emit) begin
      out_status  <= emit_status;
      out_granted <= emit_granted;
      out_used    <= usage_next;
    end
  end

  // link memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      links[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= links[mem_raddr];
    end
  end

  assign m_tdata = {4'd0, out_used, out_granted};
  assign m_tuser = out_status;

  // ---------------- configuration ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      refill_cfg <= REFILL_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_BLOCKS_PER_REFILL)) begin
      refill_cfg <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_BLOCKS_PER_REFILL) ? {26'd0, refill_cfg} : 32'd0;

  // ---------------- assertions ----------------
  `SCFL_ASSERT_NEXT(a_accept_exec, clk, rst, s_tvalid && s_tready, state == S_EXEC)
  `SCFL_ASSERT(a_cursor_bound, clk, rst, 1'b1, cursor <= LIST_EMPTY)
  `SCFL_ASSERT(a_pop_head, clk, rst, state == S_POP, cls_head == {1'b0, pop_addr})
  `SCFL_ASSERT(a_carve_count, clk, rst, state == S_CARVE, carve_idx < want)
  `SCFL_ASSERT(a_grant_zero, clk, rst, m_tvalid && (out_status != ST_OK), out_granted == '0)

endmodule

`default_nettype wire
